// ===== rtl/core/trilc_pkg.sv =====
`default_nettype none
package trilc_pkg;

  // clock and rate constants
  localparam int unsigned CPU_CLOCK           = 1789773;
  localparam int unsigned SAMPLE_RATE_HZ      = 44100;
  localparam int unsigned LINEAR_TICK_SAMPLES = 183;

  // register write thresholds
  localparam int unsigned TIMER_MIN = 8;
  localparam int unsigned FREQ_MIN  = 30;

  // widths
  localparam int unsigned PHASE_W  = 24;
  localparam int unsigned STEP_W   = 24;
  localparam int unsigned FREQ_W   = 14;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned TIMER_W  = 11;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TICK_W   = $clog2(LINEAR_TICK_SAMPLES + 1);

  // serial divider: dividend left aligned in DIVQ_W bits, divisor DIVD_W bits
  localparam int unsigned DIVQ_W   = 24;
  localparam int unsigned DIVD_W   = 14;
  localparam int unsigned DIVC_W   = $clog2(DIVQ_W + 1);

  // cpu clock over sixteen, then divided by timer + 1
  localparam int unsigned DIV1_NUM  = CPU_CLOCK / 16;
  localparam int unsigned DIV1_BITS = $clog2(DIV1_NUM + 1);
  localparam int unsigned DIV2_BITS = $clog2(SAMPLE_RATE_HZ + 1);
  localparam int unsigned DIV3_BITS = DIVQ_W;

  localparam logic [DIVQ_W-1:0] DIV1_ALIGNED =
    DIVQ_W'(DIV1_NUM) << (DIVQ_W - DIV1_BITS);
  localparam logic [DIVQ_W-1:0] DIV2_ALIGNED =
    DIVQ_W'(SAMPLE_RATE_HZ) << (DIVQ_W - DIV2_BITS);
  localparam logic [DIVQ_W-1:0] FOUR_Q21 = DIVQ_W'(24'h800000);

  localparam logic signed [PHASE_W-1:0] ONE_Q21     = 24'sh200000;
  localparam logic signed [PHASE_W-1:0] NEG_ONE_Q21 = -24'sh200000;
  localparam logic signed [PHASE_W+1:0] PHASE_MAX   = 26'sh07FFFFF;
  localparam logic signed [PHASE_W+1:0] PHASE_MIN   = -26'sh0800000;

  typedef logic [3:0] upc_t;

  // microcode addresses
  localparam upc_t ADDR_IDLE      = 4'd0;
  localparam upc_t ADDR_WR_FLAGS  = 4'd1;
  localparam upc_t ADDR_DIV1_LOAD = 4'd2;
  localparam upc_t ADDR_DIV1_LOOP = 4'd3;
  localparam upc_t ADDR_F_CHECK   = 4'd4;
  localparam upc_t ADDR_DIV2_LOAD = 4'd5;
  localparam upc_t ADDR_DIV2_LOOP = 4'd6;
  localparam upc_t ADDR_DIV3_LOAD = 4'd7;
  localparam upc_t ADDR_DIV3_LOOP = 4'd8;
  localparam upc_t ADDR_STORE     = 4'd9;
  localparam upc_t ADDR_TICK      = 4'd10;
  localparam upc_t ADDR_CLAMP     = 4'd11;
  localparam upc_t ADDR_EMIT      = 4'd12;
  localparam upc_t ADDR_EMIT_ZERO = 4'd13;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_WR_FLAGS,
    OP_DIV1_LOAD,
    OP_DIV_STEP,
    OP_DIV2_LOAD,
    OP_DIV3_LOAD,
    OP_STORE_STEP,
    OP_CLAMP,
    OP_EMIT_STEP,
    OP_EMIT_ZERO
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_DISPATCH,
    COND_TIMER_LOW,
    COND_DIV_MORE,
    COND_F_LOW,
    COND_FREQ_ZERO
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic go;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic timer_low;
    logic div_more;
    logic f_low;
    logic freq_zero;
    logic out_free;
  } status_t;

  function automatic logic op_emits(input op_t op);
    return (op == OP_EMIT_STEP) || (op == OP_EMIT_ZERO);
  endfunction

  // control store
  function automatic uword_t ucode(input upc_t addr);
    uword_t w;
    case (addr)
      ADDR_IDLE:      w = '{OP_CAPTURE,    COND_DISPATCH,  ADDR_IDLE};
      ADDR_WR_FLAGS:  w = '{OP_WR_FLAGS,   COND_TIMER_LOW, ADDR_IDLE};
      ADDR_DIV1_LOAD: w = '{OP_DIV1_LOAD,  COND_NEXT,      ADDR_IDLE};
      ADDR_DIV1_LOOP: w = '{OP_DIV_STEP,   COND_DIV_MORE,  ADDR_DIV1_LOOP};
      ADDR_F_CHECK:   w = '{OP_NOP,        COND_F_LOW,     ADDR_IDLE};
      ADDR_DIV2_LOAD: w = '{OP_DIV2_LOAD,  COND_NEXT,      ADDR_IDLE};
      ADDR_DIV2_LOOP: w = '{OP_DIV_STEP,   COND_DIV_MORE,  ADDR_DIV2_LOOP};
      ADDR_DIV3_LOAD: w = '{OP_DIV3_LOAD,  COND_NEXT,      ADDR_IDLE};
      ADDR_DIV3_LOOP: w = '{OP_DIV_STEP,   COND_DIV_MORE,  ADDR_DIV3_LOOP};
      ADDR_STORE:     w = '{OP_STORE_STEP, COND_ALWAYS,    ADDR_IDLE};
      ADDR_TICK:      w = '{OP_NOP,        COND_FREQ_ZERO, ADDR_EMIT_ZERO};
      ADDR_CLAMP:     w = '{OP_CLAMP,      COND_NEXT,      ADDR_IDLE};
      ADDR_EMIT:      w = '{OP_EMIT_STEP,  COND_ALWAYS,    ADDR_IDLE};
      ADDR_EMIT_ZERO: w = '{OP_EMIT_ZERO,  COND_ALWAYS,    ADDR_IDLE};
      default:        w = '{OP_NOP,        COND_ALWAYS,    ADDR_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/trilc_div.sv =====
`default_nettype none
module trilc_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire logic                          step,
  input  wire logic [trilc_pkg::DIVQ_W-1:0]  num,
  input  wire logic [trilc_pkg::DIVD_W-1:0]  den,
  input  wire logic [trilc_pkg::DIVC_W-1:0]  bits,
  output logic      [trilc_pkg::DIVQ_W-1:0]  quo,
  output logic                               more
);

  logic [trilc_pkg::DIVD_W-1:0] rem;
  logic [trilc_pkg::DIVD_W-1:0] den_q;
  logic [trilc_pkg::DIVC_W-1:0] cnt;
  logic [trilc_pkg::DIVD_W:0]   rem_sh;
  logic [trilc_pkg::DIVD_W+1:0] diff;

  // restoring division, one quotient bit a cycle
  assign rem_sh = {rem, quo[trilc_pkg::DIVQ_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign more   = cnt > trilc_pkg::DIVC_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= bits;
    end else if (step && (cnt != '0)) begin
      cnt <= cnt - trilc_pkg::DIVC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
    end else if (step && (cnt != '0)) begin
      if (!diff[trilc_pkg::DIVD_W+1]) begin
        rem <= diff[trilc_pkg::DIVD_W-1:0];
        quo <= {quo[trilc_pkg::DIVQ_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[trilc_pkg::DIVD_W-1:0];
        quo <= {quo[trilc_pkg::DIVQ_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/trilc_seq.sv =====
`default_nettype none
module trilc_seq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                func,
  input  wire trilc_pkg::status_t  status,
  output logic                     in_stall,
  output trilc_pkg::ctrl_t         ctrl
);

  trilc_pkg::upc_t   upc;
  trilc_pkg::upc_t   upc_next;
  trilc_pkg::uword_t word;
  logic              advance;
  logic              take;

  assign word     = trilc_pkg::ucode(upc);
  assign in_stall = upc != trilc_pkg::ADDR_IDLE;

  // an emitting step waits for room in the output register
  assign advance  = !(trilc_pkg::op_emits(word.op) && !status.out_free);

  always_comb begin
    take = 1'b0;
    case (word.cond)
      trilc_pkg::COND_NEXT:      take = 1'b0;
      trilc_pkg::COND_ALWAYS:    take = 1'b1;
      trilc_pkg::COND_DISPATCH:  take = 1'b0;
      trilc_pkg::COND_TIMER_LOW: take = status.timer_low;
      trilc_pkg::COND_DIV_MORE:  take = status.div_more;
      trilc_pkg::COND_F_LOW:     take = status.f_low;
      trilc_pkg::COND_FREQ_ZERO: take = status.freq_zero;
      default:                   take = 1'b1;
    endcase
  end

  always_comb begin
    upc_next = upc;
    if (word.cond == trilc_pkg::COND_DISPATCH) begin
      if (in_valid) begin
        upc_next = func ? trilc_pkg::ADDR_TICK : trilc_pkg::ADDR_WR_FLAGS;
      end
    end else if (advance) begin
      upc_next = take ? word.target : upc + trilc_pkg::upc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= trilc_pkg::ADDR_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  always_comb begin
    ctrl.op = word.op;
    if (word.cond == trilc_pkg::COND_DISPATCH) begin
      ctrl.go = in_valid;
    end else begin
      ctrl.go = advance;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/trilc_dp.sv =====
`default_nettype none
module trilc_dp (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire trilc_pkg::ctrl_t                       ctrl,
  input  wire logic [7:0]                             linear_byte,
  input  wire logic [7:0]                             length_byte,
  input  wire logic [7:0]                             timer_low,
  input  wire logic [7:0]                             timer_high,
  input  wire logic                                   out_stall,
  output trilc_pkg::status_t                          status,
  output logic                                        out_valid,
  output logic signed [trilc_pkg::SAMPLE_W-1:0]       sample
);

  // captured item
  logic [7:0]                            lin_q;
  logic [7:0]                            len_q;
  logic [trilc_pkg::TIMER_W-1:0]         timer_q;

  // voice state
  logic signed [trilc_pkg::PHASE_W-1:0]  phase;
  logic                                  rising;
  logic                                  halted;
  logic [trilc_pkg::COUNT_W-1:0]         linear_count;
  logic [trilc_pkg::FREQ_W-1:0]          tone_frequency;
  logic [trilc_pkg::STEP_W-1:0]          phase_step;
  logic [trilc_pkg::TICK_W-1:0]          tick_divider;

  // divider hookup
  logic                                  div_load;
  logic                                  div_step;
  logic [trilc_pkg::DIVQ_W-1:0]          div_num;
  logic [trilc_pkg::DIVD_W-1:0]          div_den;
  logic [trilc_pkg::DIVC_W-1:0]          div_bits;
  logic [trilc_pkg::DIVQ_W-1:0]          quo;
  logic                                  div_more;

  logic                                  go;
  logic signed [trilc_pkg::PHASE_W+1:0]  phase_sum;
  logic signed [trilc_pkg::PHASE_W-1:0]  phase_next;
  logic [trilc_pkg::TICK_W-1:0]          tick_inc;
  logic                                  tick_wrap;
  logic                                  muted;
  logic                                  out_load;
  logic signed [trilc_pkg::SAMPLE_W-1:0] sample_next;

  assign go = ctrl.go;

  always_comb begin
    div_load = go && ((ctrl.op == trilc_pkg::OP_DIV1_LOAD) ||
                      (ctrl.op == trilc_pkg::OP_DIV2_LOAD) ||
                      (ctrl.op == trilc_pkg::OP_DIV3_LOAD));
    div_step = go && (ctrl.op == trilc_pkg::OP_DIV_STEP);
    div_num  = trilc_pkg::DIV1_ALIGNED;
    div_den  = trilc_pkg::DIVD_W'(timer_q) + trilc_pkg::DIVD_W'(1);
    div_bits = trilc_pkg::DIVC_W'(trilc_pkg::DIV1_BITS);
    case (ctrl.op)
      trilc_pkg::OP_DIV2_LOAD: begin
        div_num  = trilc_pkg::DIV2_ALIGNED;
        div_den  = quo[trilc_pkg::DIVD_W-1:0];
        div_bits = trilc_pkg::DIVC_W'(trilc_pkg::DIV2_BITS);
      end
      trilc_pkg::OP_DIV3_LOAD: begin
        div_num  = trilc_pkg::FOUR_Q21;
        div_den  = (quo == '0) ? trilc_pkg::DIVD_W'(1) : quo[trilc_pkg::DIVD_W-1:0];
        div_bits = trilc_pkg::DIVC_W'(trilc_pkg::DIV3_BITS);
      end
      default: begin
      end
    endcase
  end

  trilc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .load (div_load),
    .step (div_step),
    .num  (div_num),
    .den  (div_den),
    .bits (div_bits),
    .quo  (quo),
    .more (div_more)
  );

  // phase step with saturation to the signed range
  always_comb begin
    if (rising) begin
      phase_sum = {{2{phase[trilc_pkg::PHASE_W-1]}}, phase} + {2'b00, phase_step};
    end else begin
      phase_sum = {{2{phase[trilc_pkg::PHASE_W-1]}}, phase} - {2'b00, phase_step};
    end
    if (phase_sum > trilc_pkg::PHASE_MAX) begin
      phase_next = trilc_pkg::PHASE_MAX[trilc_pkg::PHASE_W-1:0];
    end else if (phase_sum < trilc_pkg::PHASE_MIN) begin
      phase_next = trilc_pkg::PHASE_MIN[trilc_pkg::PHASE_W-1:0];
    end else begin
      phase_next = phase_sum[trilc_pkg::PHASE_W-1:0];
    end
  end

  assign tick_inc  = tick_divider + trilc_pkg::TICK_W'(1);
  assign tick_wrap = tick_inc >= trilc_pkg::TICK_W'(trilc_pkg::LINEAR_TICK_SAMPLES);
  assign muted     = halted || (linear_count == '0);

  // phase is clamped to +-1 here, so bits 22..7 carry floor(phase / 128)
  always_comb begin
    if (muted || (ctrl.op == trilc_pkg::OP_EMIT_ZERO)) begin
      sample_next = '0;
    end else begin
      sample_next = phase[trilc_pkg::SAMPLE_W+6:7];
    end
  end

  assign out_load = go && trilc_pkg::op_emits(ctrl.op);

  always_ff @(posedge clk) begin
    if (go && (ctrl.op == trilc_pkg::OP_CAPTURE)) begin
      lin_q   <= linear_byte;
      len_q   <= length_byte;
      timer_q <= {timer_high[2:0], timer_low};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= '0;
      rising         <= 1'b0;
      halted         <= 1'b0;
      linear_count   <= '0;
      tone_frequency <= '0;
      phase_step     <= '0;
      tick_divider   <= '0;
    end else if (go) begin
      case (ctrl.op)
        trilc_pkg::OP_WR_FLAGS: begin
          if (len_q != '0) begin
            linear_count <= lin_q[trilc_pkg::COUNT_W-1:0];
          end
          // control bit clear releases the halt
          halted <= lin_q[7] && ((len_q != '0) || halted);
        end
        trilc_pkg::OP_DIV2_LOAD: begin
          tone_frequency <= quo[trilc_pkg::FREQ_W-1:0];
        end
        trilc_pkg::OP_STORE_STEP: begin
          phase_step <= quo[trilc_pkg::STEP_W-1:0];
        end
        trilc_pkg::OP_CLAMP: begin
          if (phase >= trilc_pkg::ONE_Q21) begin
            phase  <= trilc_pkg::ONE_Q21;
            rising <= 1'b0;
          end else if (phase <= trilc_pkg::NEG_ONE_Q21) begin
            phase  <= trilc_pkg::NEG_ONE_Q21;
            rising <= 1'b1;
          end
        end
        trilc_pkg::OP_EMIT_STEP: begin
          phase <= phase_next;
          if (tick_wrap) begin
            tick_divider <= '0;
            if (linear_count != '0) begin
              linear_count <= linear_count - trilc_pkg::COUNT_W'(1);
            end
          end else begin
            tick_divider <= tick_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample <= sample_next;
    end
  end

  always_comb begin
    status.timer_low = timer_q < trilc_pkg::TIMER_W'(trilc_pkg::TIMER_MIN);
    status.div_more  = div_more;
    status.f_low     = quo < trilc_pkg::DIVQ_W'(trilc_pkg::FREQ_MIN);
    status.freq_zero = tone_frequency == '0;
    status.out_free  = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire

// ===== rtl/core/triangle_wave_voice_with_linear_counter_core.sv =====
// channel  dir  handshake          payload
// in       in   in_valid/in_stall  func, linear_byte, length_byte, timer_low, timer_high
// out      out  out_valid/out_stall sample (signed q1.15)
//
// register write: three serial divisions, one quotient bit a cycle, none when
// the timer is below eight and only the first when the tone is too low
// sample tick: clamp then emit, or only an emit of zero while the tone frequency is zero
// synchronous reset clears the sequencer, the voice state and the output valid
// a stalled output holds the finished item; the sequencer waits on its emit
// step while the output register is full and stalled, and a new item is taken only at idle
`default_nettype none
module triangle_wave_voice_with_linear_counter_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  func,
  input  wire logic [7:0]                            linear_byte,
  input  wire logic [7:0]                            length_byte,
  input  wire logic [7:0]                            timer_low,
  input  wire logic [7:0]                            timer_high,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [trilc_pkg::SAMPLE_W-1:0]      sample
);

  // control word handed from the sequencer to the datapath each cycle
  trilc_pkg::ctrl_t   ctrl;
  // flags the microcode branches on
  trilc_pkg::status_t status;

  // step counter, control store and branch logic
  trilc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .status   (status),
    .in_stall (in_stall),
    .ctrl     (ctrl)
  );

  // voice registers, serial divider and output register
  trilc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .linear_byte (linear_byte),
    .length_byte (length_byte),
    .timer_low   (timer_low),
    .timer_high  (timer_high),
    .out_stall   (out_stall),
    .status      (status),
    .out_valid   (out_valid),
    .sample      (sample)
  );

endmodule
`default_nettype wire

// ===== rtl/core/trilc_chk.sv =====
`default_nettype none
module trilc_chk (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_stall,
  input wire logic                                func,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic signed [trilc_pkg::SAMPLE_W-1:0] sample
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample))
    else $error("stalled output item changed");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while item in progress");

  // sample stays within +-0.5
  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sample <= 16'sd16384) && (sample >= -16'sd16384))
    else $error("sample out of range");

  // register writes never produce a result on the next edge
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !func && !out_valid |=> !out_valid)
    else $error("register write produced an item");

  // reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind triangle_wave_voice_with_linear_counter_core trilc_chk u_trilc_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .func      (func),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .sample    (sample)
);
`default_nettype wire

// ===== dv/triangle_wave_voice_with_linear_counter_core_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module triangle_wave_voice_with_linear_counter_core_tb;

  // item kinds on the func field
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // tone arithmetic, from the chip clock down to the audio rate
  localparam int unsigned CPU_HZ      = 1789773;
  localparam int unsigned RATE_HZ     = 44100;
  localparam int unsigned TICKS_PER_COUNT = 183;
  localparam int unsigned TIMER_FLOOR = 8;
  localparam int unsigned FREQ_FLOOR  = 30;
  localparam int unsigned STEP_FOUR   = 32'h0080_0000;

  localparam logic signed [23:0] PH_ONE     = 24'sh200000;
  localparam logic signed [23:0] PH_NEG_ONE = -24'sh200000;
  localparam longint PH_TOP    = 64'sh7F_FFFF;
  localparam longint PH_BOTTOM = -64'sh80_0000;

  // run control
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned PHASE_ITEMS  = 670;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 80;
  localparam int unsigned DIRECTED_ROWS = 23;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = FUNC_WRITE;
  logic [7:0] linear_byte = '0;
  logic [7:0] length_byte = '0;
  logic [7:0] timer_low = '0;
  logic [7:0] timer_high = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [trilc_pkg::SAMPLE_W-1:0] sample;

  triangle_wave_voice_with_linear_counter_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .linear_byte(linear_byte),
    .length_byte(length_byte),
    .timer_low(timer_low),
    .timer_high(timer_high),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample(sample)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // voice state as the testbench sees it
  logic signed [23:0] tone_phase;
  logic tone_rising;
  logic tone_halted;
  logic tone_ctrl;
  logic [6:0] tone_count;
  logic [13:0] tone_freq;
  logic [23:0] tone_step;
  int unsigned tone_tick_div;

  logic signed [15:0] pending_samples[$];
  int unsigned mismatch_count = 0;
  int unsigned offered_items = 0;
  int unsigned cycle_count = 0;

  // idling controls, set per phase by the stimulus
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_request = 1'b0;
  int unsigned hold_left = 0;

  // one row of the directed table; known marks an expectation typed in by hand
  typedef struct packed {
    logic fn;
    logic [7:0] lb;
    logic [7:0] nb;
    logic [7:0] tl;
    logic [7:0] th;
    logic known;
    logic signed [15:0] typed;
  } tone_row_t;

  tone_row_t directed_rows [DIRECTED_ROWS] = '{
    // tick straight after reset: no tone yet, so silence
    '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 16'sd0},
    // tick with every payload bit set, payload is ignored
    '{FUNC_TICK,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 16'sd0},
    // timer of seven is below the floor, only the flags move
    '{FUNC_WRITE, 8'hFF, 8'h00, 8'h07, 8'h00, 1'b0, 16'sd0},
    '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 16'sd0},
    // largest timer, junk in the upper timer_high bits, counter loaded full
    '{FUNC_WRITE, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b0, 16'sd0},
    // phase still at zero on the first audible tick
    '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 16'sd0},
    '{FUNC_TICK,  8'h12, 8'h34, 8'h56, 8'h78, 1'b0, 16'sd0},
    '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'sd0},
    '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'sd0},
    // smallest accepted timer gives the biggest step, so the clamps are hit
    '{FUNC_WRITE, 8'h00, 8'h00, 8'h08, 8'hF8, 1'b0, 16'sd0},
    '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'sd0},
    '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'sd0},
    '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'sd0},
    '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'sd0},
    // control set with a length: halted, so muted while the phase moves on
    '{FUNC_WRITE, 8'h85, 8'h01, 8'h00, 8'h00, 1'b0, 16'sd0},
    '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 16'sd0},
    '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 16'sd0},
    // linear counter loaded with zero: muted as well
    '{FUNC_WRITE, 8'h00, 8'h10, 8'h00, 8'h01, 1'b0, 16'sd0},
    '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 16'sd0},
    // back to an audible tone
    '{FUNC_WRITE, 8'h40, 8'h80, 8'h55, 8'h02, 1'b0, 16'sd0},
    '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'sd0},
    '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'sd0},
    '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'sd0}
  };

  // work out what one item does to the voice and what sample, if any, it yields
  task automatic predict_tone(input logic fn, input logic [7:0] lb, input logic [7:0] nb,
                              input logic [7:0] tl, input logic [7:0] th,
                              output bit emits, output logic signed [15:0] smp);
    int unsigned timer;
    int unsigned freq;
    int unsigned ratio;
    longint nxt;
    logic signed [23:0] scaled;
    emits = 1'b0;
    smp = '0;
    if (fn == FUNC_WRITE) begin
      if (nb != 8'h00) begin
        tone_halted = 1'b1;
        tone_count = lb[6:0];
      end
      tone_ctrl = lb[7];
      if (!tone_ctrl) tone_halted = 1'b0;
      timer = {21'd0, th[2:0], tl};
      if (timer >= TIMER_FLOOR) begin
        freq = CPU_HZ / (16 * (timer + 1));
        if (freq >= FREQ_FLOOR) begin
          tone_freq = freq[13:0];
          ratio = RATE_HZ / freq;
          if (ratio == 0) ratio = 1;
          tone_step = 24'(STEP_FOUR / ratio);
        end
      end
    end else begin
      emits = 1'b1;
      // silent tone leaves the whole voice untouched
      if (tone_freq != '0) begin
        if (tone_phase >= PH_ONE) begin
          tone_phase = PH_ONE;
          tone_rising = 1'b0;
        end else if (tone_phase <= PH_NEG_ONE) begin
          tone_phase = PH_NEG_ONE;
          tone_rising = 1'b1;
        end
        // half the phase, rounded towards minus infinity
        scaled = tone_phase >>> 7;
        if (!tone_halted && tone_count != '0) smp = scaled[15:0];
        if (tone_rising) nxt = longint'(tone_phase) + longint'(tone_step);
        else nxt = longint'(tone_phase) - longint'(tone_step);
        if (nxt > PH_TOP) nxt = PH_TOP;
        if (nxt < PH_BOTTOM) nxt = PH_BOTTOM;
        tone_phase = nxt[23:0];
        tone_tick_div++;
        if (tone_tick_div >= TICKS_PER_COUNT) begin
          tone_tick_div = 0;
          if (tone_count != '0) tone_count = tone_count - 7'd1;
        end
      end
    end
  endtask

  // offer one item, wait for it to be taken, then record what should come out
  task automatic offer(input logic fn, input logic [7:0] lb, input logic [7:0] nb,
                       input logic [7:0] tl, input logic [7:0] th,
                       input bit known, input logic signed [15:0] typed);
    bit emits;
    logic signed [15:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    linear_byte <= lb;
    length_byte <= nb;
    timer_low <= tl;
    timer_high <= th;
    do @(posedge clk); while (in_stall);
    predict_tone(fn, lb, nb, tl, th, emits, predicted);
    if (emits) pending_samples.push_back(known ? typed : predicted);
    offered_items++;
  endtask

  // sender pause: nothing offered until every sample has been seen
  task automatic drain_samples();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_samples.size() != 0);
  endtask

  task automatic send_random_tick();
    offer(FUNC_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
          8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0, '0);
  endtask

  // register write biased towards tones that are heard and change quickly
  task automatic send_random_write();
    logic [7:0] lb;
    logic [7:0] nb;
    logic [7:0] th;
    logic [10:0] tmr;
    int unsigned pick;
    lb = 8'($urandom_range(255));
    if ($urandom_range(4) == 0) lb[6:0] = 7'($urandom_range(3));
    nb = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
    pick = $urandom_range(99);
    if (pick < 15) tmr = 11'($urandom_range(7));
    else if (pick < 25) tmr = pick[0] ? 11'd2047 : 11'd8;
    else if (pick < 55) tmr = 11'($urandom_range(100, 8));
    else tmr = 11'($urandom_range(2047, 8));
    th = 8'($urandom_range(255));
    th[2:0] = tmr[10:8];
    offer(FUNC_WRITE, lb, nb, tmr[7:0], th, 1'b0, '0);
  endtask

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker: every sample taken is compared with the oldest one owed
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        $error("sample: expected none, got %0d", sample);
        mismatch_count++;
      end else begin
        if (sample !== pending_samples[0]) begin
          $error("sample: expected %0d, got %0d", pending_samples[0], sample);
          mismatch_count++;
        end
        void'(pending_samples.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned phase_no;
    int unsigned target;
    int unsigned burst;
    tone_phase = '0;
    tone_rising = 1'b0;
    tone_halted = 1'b0;
    tone_ctrl = 1'b0;
    tone_count = '0;
    tone_freq = '0;
    tone_step = '0;
    tone_tick_div = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, no idling on either side
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      offer(directed_rows[r].fn, directed_rows[r].lb, directed_rows[r].nb,
            directed_rows[r].tl, directed_rows[r].th,
            directed_rows[r].known, directed_rows[r].typed);
    end
    drain_samples();

    // random part in three phases: sender idles little, then receiver
    // stalls little, then neither side idles
    for (phase_no = 0; phase_no < 3; phase_no++) begin
      case (phase_no)
        0: begin
          send_idle_pct = 22;
          recv_stall_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_stall_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          // long receiver hold-off while items keep coming, fills the block
          hold_request = 1'b1;
        end
      endcase
      target = offered_items + PHASE_ITEMS;
      while (offered_items < target) begin
        // mostly a write followed by a run of ticks, sometimes ticks alone
        if ($urandom_range(9) != 0) send_random_write();
        burst = ($urandom_range(7) == 0) ? $urandom_range(400, 60) : $urandom_range(60, 1);
        repeat (burst) send_random_tick();
      end
      drain_samples();
    end

    // let a trailing register write finish and catch any stray sample
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_samples.size() != 0) begin
      $error("sample: %0d expected results never arrived", pending_samples.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
